FILE: rtl/qrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg: shared constants for the quadratic root solver
// Status codes and default widths.
// ----------------------------------------------------------------------------
package qrs_pkg;
    localparam int COEFF_BITS_DEF = 16;
    localparam int ROOT_BITS_DEF  = 32;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_AZERO = 2'd1;
    localparam logic [1:0] ST_IMAG = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/qrs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_front: coefficient intake and classification
// Registers a beat, forms b*b and 4ac, then the discriminant and status.
// Fully pipelined, one beat per cycle unless stalled; stalls as a whole.
// ----------------------------------------------------------------------------
module qrs_front #(
    parameter int COEFF_BITS = qrs_pkg::COEFF_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COEFF_BITS-1:0]  a_in,
    input  wire logic signed [COEFF_BITS-1:0]  b_in,
    input  wire logic signed [COEFF_BITS-1:0]  c_in,
    input  wire logic [1:0]                    op_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         out_status,
    output logic [1:0]                         out_op,
    output logic signed [COEFF_BITS-1:0]       out_a,
    output logic signed [COEFF_BITS-1:0]       out_b,
    output logic [2*COEFF_BITS+1:0]            out_disc
);
    localparam int PW = 2 * COEFF_BITS + 3;
    logic v1_reg, v2_reg;
    logic signed [COEFF_BITS-1:0] a1_reg, b1_reg, c1_reg, a2_reg, b2_reg;
    logic [1:0] op1_reg, op2_reg;
    logic signed [PW-1:0] bb_reg, ac4_reg, disc;
    logic [1:0] st2;
    logic adv;

    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign disc = bb_reg - ac4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= a_in;
            b1_reg <= b_in;
            c1_reg <= c_in;
            op1_reg <= op_in;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            op2_reg <= op1_reg;
            bb_reg <= PW'(b1_reg * b1_reg);
            ac4_reg <= PW'(a1_reg * c1_reg) <<< 2;
        end
    end

    always_comb
    begin
        priority if (a2_reg == '0)
            st2 = qrs_pkg::ST_AZERO;
        else if (disc[PW-1])
            st2 = qrs_pkg::ST_IMAG;
        else
            st2 = qrs_pkg::ST_OK;
    end

    assign out_valid  = v2_reg;
    assign out_status = st2;
    assign out_op     = op2_reg;
    assign out_a      = a2_reg;
    assign out_b      = b2_reg;
    assign out_disc   = disc[PW-2:0];
endmodule
`default_nettype wire

FILE: rtl/qrs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_queue: small beat queue between front and back
// Four-entry register FIFO; stall asserted when full.
// ----------------------------------------------------------------------------
module qrs_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [W-1:0]      out_data
);
    logic [W-1:0] mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;

    assign in_stall  = cnt_reg[2];
    assign out_valid = cnt_reg != 3'd0;
    assign wr = in_valid && !in_stall;
    assign rd = out_valid && !out_stall;
    assign out_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 2'd1;
            if (rd)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, wr} - {2'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= in_data;
    end
endmodule
`default_nettype wire

FILE: rtl/qrs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_back: square root, two divisions, saturation
// Pipelined: one root bit per stage, then one quotient bit per stage for
// both numerators in parallel, then sign fix, saturation and masking.
// ----------------------------------------------------------------------------
module qrs_back #(
    parameter int COEFF_BITS = qrs_pkg::COEFF_BITS_DEF,
    parameter int ROOT_BITS  = qrs_pkg::ROOT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    in_status,
    input  wire logic [1:0]                    in_op,
    input  wire logic signed [COEFF_BITS-1:0]  in_a,
    input  wire logic signed [COEFF_BITS-1:0]  in_b,
    input  wire logic [2*COEFF_BITS+1:0]       in_disc,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic signed [ROOT_BITS-1:0]        root_plus,
    output logic signed [ROOT_BITS-1:0]        root_minus,
    output logic                               plus_valid,
    output logic                               minus_valid
);
    localparam int DW = 2 * COEFF_BITS + 2;     // discriminant bits
    localparam int XW = DW + 16;                // disc << 16
    localparam int SB = XW / 2;                 // root bits
    localparam int NW = SB + 10;                // magnitude of numerator * 256
    localparam int DN = COEFF_BITS + 1;         // magnitude of 2a
    localparam int NS = SB + NW + 2;

    logic v_reg [NS+1];
    logic [1:0] st_reg [NS+1];
    logic [1:0] op_reg [NS+1];
    logic [COEFF_BITS-1:0] a_reg [SB+1];
    logic signed [COEFF_BITS-1:0] b_reg [SB+1];
    logic [XW-1:0] x_reg [SB+1];
    logic [SB+1:0] r_reg [SB+1];
    logic [SB-1:0] q_reg [SB+1];
    logic [NW-1:0] np_reg [NW+1], nm_reg [NW+1];
    logic [DN-1:0] d_reg [NW+1];
    logic [DN:0] remp_reg [NW+1], remm_reg [NW+1];
    logic sp_reg [NW+1], sm_reg [NW+1];
    logic [ROOT_BITS-1:0] rp_reg, rm_reg;
    logic adv;

    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= in_status;
            op_reg[0] <= in_op;
            for (int i = 1; i <= NS; i++)
            begin
                st_reg[i] <= st_reg[i-1];
                op_reg[i] <= op_reg[i-1];
            end
        end
    end

    // square root, restoring, one bit per stage from the top
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg[0] <= in_a;
            b_reg[0] <= in_b;
            x_reg[0] <= {in_disc, 16'b0};
            r_reg[0] <= '0;
            q_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SB; k++)
    begin : g_sqrt
        logic [SB+1:0] rem2, trial;
        logic [SB-1:0] qn;
        assign rem2  = {r_reg[k][SB-1:0], x_reg[k][XW-1-2*k -: 2]};
        assign trial = {q_reg[k], 2'b01};
        assign qn    = {q_reg[k][SB-2:0], 1'b0};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_reg[k+1] <= a_reg[k];
                b_reg[k+1] <= b_reg[k];
                x_reg[k+1] <= x_reg[k];
                if (rem2 >= trial)
                begin
                    r_reg[k+1] <= rem2 - trial;
                    q_reg[k+1] <= qn | SB'(1);
                end
                else
                begin
                    r_reg[k+1] <= rem2;
                    q_reg[k+1] <= qn;
                end
            end
        end
    end

    // numerators nb +/- s as sign and magnitude, denominator 2a
    logic signed [NW:0] nb, nps, nms;
    logic signed [DN-1:0] den;
    assign nb  = -((NW+1)'(b_reg[SB]) <<< 8);
    assign nps = nb + (NW+1)'(q_reg[SB]);
    assign nms = nb - (NW+1)'(q_reg[SB]);
    assign den = DN'(signed'(a_reg[SB])) <<< 1;

    // scale each numerator magnitude by 256 ahead of the division
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_reg[0] <= nps[NW] ^ den[DN-1];
            sm_reg[0] <= nms[NW] ^ den[DN-1];
            np_reg[0] <= (nps[NW] ? NW'(-nps) : NW'(nps)) << 8;
            nm_reg[0] <= (nms[NW] ? NW'(-nms) : NW'(nms)) << 8;
            d_reg[0]  <= den[DN-1] ? DN'(-den) : DN'(den);
            remp_reg[0] <= '0;
            remm_reg[0] <= '0;
        end
    end

    // long division, one quotient bit per stage, quotient shifts into numerator
    for (genvar k = 0; k < NW; k++)
    begin : g_div
        logic [DN:0] tp, tm;
        assign tp = {remp_reg[k][DN-1:0], np_reg[k][NW-1]};
        assign tm = {remm_reg[k][DN-1:0], nm_reg[k][NW-1]};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[k+1]  <= d_reg[k];
                sp_reg[k+1] <= sp_reg[k];
                sm_reg[k+1] <= sm_reg[k];
                if (tp >= {1'b0, d_reg[k]})
                begin
                    remp_reg[k+1] <= tp - {1'b0, d_reg[k]};
                    np_reg[k+1]   <= {np_reg[k][NW-2:0], 1'b1};
                end
                else
                begin
                    remp_reg[k+1] <= tp;
                    np_reg[k+1]   <= {np_reg[k][NW-2:0], 1'b0};
                end
                if (tm >= {1'b0, d_reg[k]})
                begin
                    remm_reg[k+1] <= tm - {1'b0, d_reg[k]};
                    nm_reg[k+1]   <= {nm_reg[k][NW-2:0], 1'b1};
                end
                else
                begin
                    remm_reg[k+1] <= tm;
                    nm_reg[k+1]   <= {nm_reg[k][NW-2:0], 1'b0};
                end
            end
        end
    end

    function automatic logic [ROOT_BITS-1:0] sat(input logic neg, input logic [NW-1:0] mag);
        logic [NW:0] maxp;
        begin
            maxp = (NW+1)'({1'b0, {(ROOT_BITS-1){1'b1}}});
            if (neg)
                sat = ({1'b0, mag} > maxp) ? {1'b1, {(ROOT_BITS-1){1'b0}}}
                                           : ROOT_BITS'(-{1'b0, mag});
            else
                sat = ({1'b0, mag} > maxp) ? {1'b0, {(ROOT_BITS-1){1'b1}}}
                                           : ROOT_BITS'({1'b0, mag});
        end
    endfunction

    logic okl;
    assign okl = st_reg[NS-1] == qrs_pkg::ST_OK;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg <= okl ? sat(sp_reg[NW], np_reg[NW]) : '0;
            rm_reg <= okl ? sat(sm_reg[NW], nm_reg[NW]) : '0;
        end
    end

    assign out_valid   = v_reg[NS];
    assign status      = st_reg[NS];
    assign root_plus   = rp_reg;
    assign root_minus  = rm_reg;
    assign plus_valid  = (st_reg[NS] == qrs_pkg::ST_OK) && op_reg[NS][0];
    assign minus_valid = (st_reg[NS] == qrs_pkg::ST_OK) && op_reg[NS][1];
endmodule
`default_nettype wire

FILE: rtl/quadratic_root_solver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver_core: real roots of a*x^2 + b*x + c in fixed point
// Front classifies, a four-beat queue decouples, back computes the roots.
// ----------------------------------------------------------------------------
// One beat enters per cycle when nothing downstream stalls. A beat
// passes the front registers, the queue and the back pipeline, whose
// stages cover SB = COEFF_BITS + 9 square-root bits (one stage per bit)
// and NW = SB + 10 quotient bits (one stage per bit). A stall at the
// output freezes the back pipeline; the queue then absorbs up to four
// beats before the input stalls.
module quadratic_root_solver_core #(
    parameter int COEFF_BITS = qrs_pkg::COEFF_BITS_DEF,
    parameter int ROOT_BITS  = qrs_pkg::ROOT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COEFF_BITS-1:0]  coeff_a,
    input  wire logic signed [COEFF_BITS-1:0]  coeff_b,
    input  wire logic signed [COEFF_BITS-1:0]  coeff_c,
    input  wire logic [1:0]                    operation,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic signed [ROOT_BITS-1:0]        root_plus,
    output logic signed [ROOT_BITS-1:0]        root_minus,
    output logic                               plus_valid,
    output logic                               minus_valid
);
    localparam int DW = 2 * COEFF_BITS + 2;
    localparam int QW = 4 + 2 * COEFF_BITS + DW;

    logic f_valid, f_stall, q_valid, q_stall;
    logic [1:0] f_status, f_op;
    logic signed [COEFF_BITS-1:0] f_a, f_b;
    logic [DW-1:0] f_disc;
    logic [QW-1:0] q_data;

    qrs_front #(.COEFF_BITS(COEFF_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_in(coeff_a), .b_in(coeff_b), .c_in(coeff_c), .op_in(operation),
        .out_valid(f_valid), .out_stall(f_stall),
        .out_status(f_status), .out_op(f_op), .out_a(f_a), .out_b(f_b),
        .out_disc(f_disc)
    );

    qrs_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_stall(f_stall),
        .in_data({f_status, f_op, f_a, f_b, f_disc}),
        .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
    );

    qrs_back #(.COEFF_BITS(COEFF_BITS), .ROOT_BITS(ROOT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_stall(q_stall),
        .in_status(q_data[QW-1 -: 2]), .in_op(q_data[QW-3 -: 2]),
        .in_a(q_data[DW+2*COEFF_BITS-1 -: COEFF_BITS]),
        .in_b(q_data[DW+COEFF_BITS-1 -: COEFF_BITS]),
        .in_disc(q_data[DW-1:0]),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .root_plus(root_plus), .root_minus(root_minus),
        .plus_valid(plus_valid), .minus_valid(minus_valid)
    );
endmodule
`default_nettype wire

FILE: rtl/qrs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_checker: port-level checks for the quadratic root solver
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker #(
    parameter int ROOT_BITS = qrs_pkg::ROOT_BITS_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [1:0]           status,
    input wire logic [ROOT_BITS-1:0] root_plus,
    input wire logic [ROOT_BITS-1:0] root_minus,
    input wire logic                 plus_valid,
    input wire logic                 minus_valid
);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == qrs_pkg::ST_OK || status == qrs_pkg::ST_AZERO
                       || status == qrs_pkg::ST_IMAG))
        else $error("bad status code");
    a_err_novalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != qrs_pkg::ST_OK |-> !plus_valid && !minus_valid)
        else $error("root valid on error status");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != qrs_pkg::ST_OK |-> root_plus == '0 && root_minus == '0)
        else $error("nonzero root on error status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root_plus) && $stable(status))
        else $error("stalled beat changed");
endmodule

bind quadratic_root_solver_core qrs_checker #(.ROOT_BITS(ROOT_BITS)) u_qrs_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .root_plus(root_plus), .root_minus(root_minus),
    .plus_valid(plus_valid), .minus_valid(minus_valid)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quadratic_root_solver_core
// Drives coefficient beats with random gaps, predicts status and both
// Q16.16 roots per beat and compares each output beat in order.
// ----------------------------------------------------------------------------
module testbench;
    localparam int CB = 16;
    localparam int RB = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] c;
        logic [1:0]           sel;
    } coeff_set_t;

    typedef struct packed {
        logic [1:0]           st;
        logic signed [RB-1:0] rp;
        logic signed [RB-1:0] rm;
        logic                 pv;
        logic                 mv;
    } roots_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CB-1:0] coeff_a = '0;
    logic signed [CB-1:0] coeff_b = '0;
    logic signed [CB-1:0] coeff_c = '0;
    logic [1:0] operation = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic signed [RB-1:0] root_plus;
    logic signed [RB-1:0] root_minus;
    logic plus_valid;
    logic minus_valid;

    coeff_set_t pending_sets[$];
    roots_t expected_roots[$];
    int errors = 0;
    int watchdog = 0;
    int in_gap = 0;
    int out_gap = 0;
    bit stimulus_done = 1'b0;
    bit quiet_tail = 1'b0;

    always #2 clk = ~clk;

    quadratic_root_solver_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .coeff_a(coeff_a), .coeff_b(coeff_b), .coeff_c(coeff_c),
        .operation(operation),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .root_plus(root_plus), .root_minus(root_minus),
        .plus_valid(plus_valid), .minus_valid(minus_valid)
    );

    function automatic longint isqrt_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [RB-1:0] sat_quotient(longint num, longint den);
        longint q;
        longint hi;
        longint lo;
        q = (num * 256) / den;
        hi = (longint'(1) <<< (RB - 1)) - 1;
        lo = -hi - 1;
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return q[RB-1:0];
    endfunction

    function automatic roots_t solve_roots(coeff_set_t s);
        roots_t r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint sq;
        a = s.a;
        b = s.b;
        c = s.c;
        r = '0;
        r.st = qrs_pkg::ST_OK;
        if (a == 0)
            r.st = qrs_pkg::ST_AZERO;
        else
        begin
            disc = b * b - 4 * a * c;
            if (disc < 0)
                r.st = qrs_pkg::ST_IMAG;
            else
            begin
                sq = isqrt_floor(longint'(disc) << 16);
                r.rp = sat_quotient(-b * 256 + sq, 2 * a);
                r.rm = sat_quotient(-b * 256 - sq, 2 * a);
                r.pv = s.sel[0];
                r.mv = s.sel[1];
            end
        end
        return r;
    endfunction

    function automatic coeff_set_t make_set(int a, int b, int c, int sel);
        coeff_set_t s;
        s.a = a[CB-1:0];
        s.b = b[CB-1:0];
        s.c = c[CB-1:0];
        s.sel = sel[1:0];
        return s;
    endfunction

    function automatic logic signed [CB-1:0] rand_coeff();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return CB'($signed($urandom_range(0, 16)) - 8);
            2: return CB'($signed($urandom_range(0, 1024)) - 512);
            default: return CB'($urandom);
        endcase
    endfunction

    // Driver: hold the beat while stalled, advance when accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                    expected_roots.push_back(solve_roots(
                        make_set(coeff_a, coeff_b, coeff_c, operation)));
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_sets.size() > 0)
                begin
                    coeff_a <= pending_sets[0].a;
                    coeff_b <= pending_sets[0].b;
                    coeff_c <= pending_sets[0].c;
                    operation <= pending_sets[0].sel;
                    void'(pending_sets.pop_front());
                    in_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        in_gap <= $urandom_range(1, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each output beat with the oldest prediction.
    always @(posedge clk)
    begin
        roots_t exp_r;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_roots.size() == 0)
                begin
                    $display("%0t: unexpected beat status=%0d", $time, status);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = expected_roots.pop_front();
                    if (status !== exp_r.st || root_plus !== exp_r.rp
                        || root_minus !== exp_r.rm || plus_valid !== exp_r.pv
                        || minus_valid !== exp_r.mv)
                    begin
                        $display("%0t: expected st=%0d rp=%0d rm=%0d pv=%0b mv=%0b",
                            $time, exp_r.st, exp_r.rp, exp_r.rm, exp_r.pv, exp_r.mv);
                        $display("%0t: actual   st=%0d rp=%0d rm=%0d pv=%0b mv=%0b",
                            $time, status, root_plus, root_minus, plus_valid,
                            minus_valid);
                        errors <= errors + 1;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet_tail && $urandom_range(0, 9) == 0)
                    out_gap <= $urandom_range(1, 5);
            end
        end
    end

    always @(posedge clk)
    begin
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("[quadratic_root_solver_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        // Directed: extremes, zero leading term, imaginary, each selector.
        pending_sets.push_back(make_set(0, 100, 5, 3));
        pending_sets.push_back(make_set(0, 0, 0, 0));
        pending_sets.push_back(make_set(256, 0, 256, 3));
        pending_sets.push_back(make_set(256, 0, -256, 3));
        pending_sets.push_back(make_set(256, -768, 512, 1));
        pending_sets.push_back(make_set(256, 512, 256, 2));
        pending_sets.push_back(make_set(256, 0, 0, 0));
        pending_sets.push_back(make_set(1, 32767, 0, 3));
        pending_sets.push_back(make_set(1, -32768, 0, 3));
        pending_sets.push_back(make_set(-1, -32768, 32767, 3));
        pending_sets.push_back(make_set(32767, 32767, 32767, 3));
        pending_sets.push_back(make_set(-32768, -32768, -32768, 3));
        pending_sets.push_back(make_set(32767, -32768, -32768, 3));
        pending_sets.push_back(make_set(-32768, 32767, 32767, 3));
        pending_sets.push_back(make_set(-1, 0, 32767, 3));
        pending_sets.push_back(make_set(1, 0, -32768, 1));
        pending_sets.push_back(make_set(-256, 256, 512, 2));
        pending_sets.push_back(make_set(-1, -1, -1, 3));
        pending_sets.push_back(make_set(-1, 5, 0, 0));
        for (int i = 0; i < 400; i++)
            pending_sets.push_back('{rand_coeff(), rand_coeff(), rand_coeff(),
                                     2'($urandom)});
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_sets.size() > 60)
            @(posedge clk);
        quiet_tail = 1'b1;
        while (pending_sets.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_roots.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[quadratic_root_solver_core] OK");
        else
            $display("[quadratic_root_solver_core] ERROR");
        $finish;
    end
endmodule
